FILE: rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, microcode format and control program of the Newton-Raphson
// square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int DATA_W       = 32;             // Q16.16 operands
  localparam int FRAC_W       = 16;
  localparam int SQ_W         = 2 * DATA_W;     // Q32.32 square
  localparam int DIV_W        = DATA_W + FRAC_W; // dividend n << 16
  localparam int ITER_W       = 7;
  localparam int MAX_ITER_DEF = 32;
  localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(1);

  typedef logic [2:0] upc_t;

  localparam upc_t STEP_IDLE = 3'd0;
  localparam upc_t STEP_SQ   = 3'd1;
  localparam upc_t STEP_ERR  = 3'd2;
  localparam upc_t STEP_CHK  = 3'd3;
  localparam upc_t STEP_DIVS = 3'd4;
  localparam upc_t STEP_DIVW = 3'd5;
  localparam upc_t STEP_UPD  = 3'd6;
  localparam upc_t STEP_OUT  = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_FINISH,
    COND_DIV_BUSY,
    COND_NO_OUT
  } cond_t;

  // One control word: a jump taken when cond holds, else fall through to the
  // next step, plus the datapath strobes for this step.
  typedef struct packed {
    cond_t cond;
    upc_t  target;
    logic  in_rdy;
    logic  out_vld;
    logic  ld;
    logic  sq;
    logic  err;
    logic  chk;
    logic  div_go;
    logic  upd;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic tol_met;
    logic at_cap;
  } stat_t;

  function automatic ctl_t ucode(input upc_t step);
    ctl_t c;
    c = '0;
    c.cond   = COND_NEVER;
    c.target = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        c.in_rdy = 1'b1;
        c.ld     = 1'b1;
        c.cond   = COND_NO_IN;
        c.target = STEP_IDLE;
      end
      STEP_SQ:   c.sq  = 1'b1;
      STEP_ERR:  c.err = 1'b1;
      STEP_CHK: begin
        c.chk    = 1'b1;
        c.cond   = COND_FINISH;
        c.target = STEP_OUT;
      end
      STEP_DIVS: c.div_go = 1'b1;
      STEP_DIVW: begin
        c.cond   = COND_DIV_BUSY;
        c.target = STEP_DIVW;
      end
      STEP_UPD: begin
        c.upd    = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = STEP_SQ;
      end
      STEP_OUT: begin
        // Falling through from the last step wraps to the idle step.
        c.out_vld = 1'b1;
        c.cond    = COND_NO_OUT;
        c.target  = STEP_OUT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/nsr_div.sv
// ----------------------------------------------------------------------------
// nsr_div
// Bit-serial restoring divider: (radicand << 16) / guess, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module nsr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nsr_pkg::DIV_W-1:0]    dividend,
  input  logic [nsr_pkg::DATA_W-1:0]   divisor,
  output logic                         busy,
  output logic [nsr_pkg::DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(nsr_pkg::DIV_W + 1);

  logic                        busy_r, busy_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [nsr_pkg::DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [nsr_pkg::DATA_W-1:0]  dvs_r, dvs_nxt;
  logic [nsr_pkg::DATA_W-1:0]  rem_r, rem_nxt;
  logic [nsr_pkg::DATA_W:0]    cand;
  logic [nsr_pkg::DATA_W+1:0]  diff;
  logic                        ge;

  // The partial remainder stays below the divisor, so the candidate fits
  // in one extra bit and the difference, when not negative, in DATA_W bits.
  assign cand = {rem_r, dvd_r[nsr_pkg::DIV_W-1]};
  assign diff = {1'b0, cand} - {2'b00, dvs_r};
  assign ge   = ~diff[nsr_pkg::DATA_W+1];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(nsr_pkg::DIV_W);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[nsr_pkg::DATA_W-1:0] : cand[nsr_pkg::DATA_W-1:0];
      dvd_nxt  = {dvd_r[nsr_pkg::DIV_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

FILE: rtl/nsr_datapath.sv
// ----------------------------------------------------------------------------
// nsr_datapath
// Guess, square, error and update registers driven by the control word,
// with the tolerance register and the serial divider.
// ----------------------------------------------------------------------------
module nsr_datapath #(
  parameter int MAX_ITER = nsr_pkg::MAX_ITER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nsr_pkg::ctl_t                 ctl,
  input  logic                          in_valid,
  input  logic [nsr_pkg::DATA_W-1:0]    in_radicand,
  input  logic                          cfg_we,
  input  logic [nsr_pkg::DATA_W-1:0]    cfg_tolerance,
  output nsr_pkg::stat_t                stat,
  output logic [nsr_pkg::DATA_W-1:0]    root,
  output logic                          converged,
  output logic [nsr_pkg::ITER_W-1:0]    iterations
);

  localparam int DW = nsr_pkg::DATA_W;
  localparam int FW = nsr_pkg::FRAC_W;
  localparam int SW = nsr_pkg::SQ_W;
  localparam int VW = nsr_pkg::DIV_W;
  localparam int IW = nsr_pkg::ITER_W;

  logic [DW-1:0] tol_r, tol_nxt;
  logic [DW-1:0] n_r, n_nxt;
  logic [DW-1:0] a_r, a_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic [SW-1:0] err_r, err_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          conv_r, conv_nxt;

  logic [SW-1:0] target;
  logic [SW-1:0] tol_wide;
  logic [VW-1:0] quot;
  logic [VW:0]   sum;
  logic [VW-1:0] half_sum;
  logic [DW-1:0] upd_sat;
  logic          div_busy;

  nsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_go),
    .dividend ({n_r, {FW{1'b0}}}),
    .divisor  (a_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign target   = {{(SW-DW-FW){1'b0}}, n_r, {FW{1'b0}}};
  assign tol_wide = {{(SW-DW-FW){1'b0}}, tol_r, {FW{1'b0}}};

  // Average of guess and quotient, saturated to the Q16.16 range and kept
  // at least one LSB so the next division has a nonzero divisor.
  assign sum      = {{(VW-DW+1){1'b0}}, a_r} + {1'b0, quot};
  assign half_sum = sum[VW:1];
  always_comb begin
    if (|half_sum[VW-1:DW]) begin
      upd_sat = '1;
    end else if (half_sum[DW-1:0] == '0) begin
      upd_sat = DW'(1);
    end else begin
      upd_sat = half_sum[DW-1:0];
    end
  end

  always_comb begin
    tol_nxt  = cfg_we ? cfg_tolerance : tol_r;
    n_nxt    = n_r;
    a_nxt    = a_r;
    sq_nxt   = sq_r;
    err_nxt  = err_r;
    iter_nxt = iter_r;
    conv_nxt = conv_r;
    if (ctl.ld && in_valid) begin
      n_nxt    = in_radicand;
      a_nxt    = (in_radicand[DW-1:1] == '0) ? DW'(1) : (in_radicand >> 1);
      iter_nxt = '0;
    end
    if (ctl.sq) begin
      sq_nxt = {{DW{1'b0}}, a_r} * {{DW{1'b0}}, a_r};
    end
    if (ctl.err) begin
      err_nxt = (sq_r >= target) ? (sq_r - target) : (target - sq_r);
    end
    if (ctl.chk) begin
      conv_nxt = stat.tol_met;
    end
    if (ctl.upd) begin
      a_nxt    = upd_sat;
      iter_nxt = iter_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= nsr_pkg::TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
    n_r    <= n_nxt;
    a_r    <= a_nxt;
    sq_r   <= sq_nxt;
    err_r  <= err_nxt;
    iter_r <= iter_nxt;
    conv_r <= conv_nxt;
  end

  assign stat.div_busy = div_busy;
  assign stat.tol_met  = (err_r <= tol_wide);
  assign stat.at_cap   = (iter_r == IW'(MAX_ITER));

  assign root       = a_r;
  assign converged  = conv_r;
  assign iterations = iter_r;

  // The guess is never zero once an item has been loaded.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.sq |-> a_r != '0)
    else $error("zero guess entered the square step");

  // A division is only started with the previous one finished.
  div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_go |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

FILE: rtl/newton_square_root_core.sv
// ----------------------------------------------------------------------------
// newton_square_root_core
// Q16.16 square root by Newton-Raphson under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters on in_valid/in_ready with an unsigned Q16.16 in_radicand.
//   The result item leaves on out_valid/out_ready as out_root (Q16.16),
//   out_converged and out_iterations. One item is worked on at a time:
//   in_ready is high only while the sequencer sits in its idle step.
//   cfg_we writes cfg_tolerance into the tolerance register in the same edge.
// Sequence:
//   After acceptance the start guess is squared and checked; each Newton
//   update then runs the bit-serial divider, which sets the rate. out_valid
//   rises after k updates (k up to MAX_ITER), and in_ready is high again in
//   the cycle right after the result item is taken.
// Reset:
//   rst_n (synchronous) returns the sequencer to idle, stops the divider and
//   sets the tolerance to one LSB.
// Stall:
//   While out_ready is low the result item is held and no new item is taken.
// ----------------------------------------------------------------------------
module newton_square_root_core #(
  parameter int MAX_ITER = nsr_pkg::MAX_ITER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nsr_pkg::DATA_W-1:0]    in_radicand,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nsr_pkg::DATA_W-1:0]    out_root,
  output logic                          out_converged,
  output logic [nsr_pkg::ITER_W-1:0]    out_iterations,
  input  logic                          cfg_we,
  input  logic [nsr_pkg::DATA_W-1:0]    cfg_tolerance
);

  nsr_pkg::upc_t  upc_r, upc_nxt;
  nsr_pkg::ctl_t  ctl;
  nsr_pkg::stat_t stat;
  logic           take;

  // Control word fetch for the current step.
  always_comb begin
    ctl = nsr_pkg::ucode(upc_r);
  end

  always_comb begin
    case (ctl.cond)
      nsr_pkg::COND_NEVER:    take = 1'b0;
      nsr_pkg::COND_ALWAYS:   take = 1'b1;
      nsr_pkg::COND_NO_IN:    take = !in_valid;
      nsr_pkg::COND_FINISH:   take = stat.tol_met || stat.at_cap;
      nsr_pkg::COND_DIV_BUSY: take = stat.div_busy;
      nsr_pkg::COND_NO_OUT:   take = !out_ready;
      default:                take = 1'b0;
    endcase
    upc_nxt = take ? ctl.target : upc_r + nsr_pkg::upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= nsr_pkg::STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign in_ready  = ctl.in_rdy;
  assign out_valid = ctl.out_vld;

  nsr_datapath #(
    .MAX_ITER (MAX_ITER)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_valid      (in_valid),
    .in_radicand   (in_radicand),
    .cfg_we        (cfg_we),
    .cfg_tolerance (cfg_tolerance),
    .stat          (stat),
    .root          (out_root),
    .converged     (out_converged),
    .iterations    (out_iterations)
  );

  // The step count never passes the cap.
  iter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iterations <= nsr_pkg::ITER_W'(MAX_ITER))
    else $error("iteration count beyond cap");

  // A result that missed the tolerance can only come from the cap.
  unconv_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_converged |-> out_iterations == nsr_pkg::ITER_W'(MAX_ITER))
    else $error("unconverged result before the cap");

  // Only one item is in flight: no intake while a result is offered.
  one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("intake open while a result is pending");

  // A taken result item returns the sequencer to idle on the next edge.
  idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !stat.div_busy)
    else $error("sequencer not idle after result item");

endmodule
